[sv/bbe_pkg.sv]
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants for the B-spline basis evaluator
// Degree, knot table depth, field widths, states, command and status structs.
// ----------------------------------------------------------------------------
package bbe_pkg;

  localparam int Degree    = 3;
  localparam int MaxCtrl   = 256;
  localparam int KnotDepth = MaxCtrl + Degree + 1;
  localparam int KW        = $clog2(KnotDepth);
  localparam int NW        = 9;
  localparam int VW        = 17;
  localparam int JW        = 3;
  localparam int BW        = 2;
  localparam int QW        = 35;
  localparam logic [VW-1:0] One = VW'(65536);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_BUILD = 10'b0000000010,
    S_END   = 10'b0000000100,
    S_SRCH  = 10'b0000001000,
    S_SRCHW = 10'b0000010000,
    S_KNOT  = 10'b0000100000,
    S_KNOTW = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_UPD   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic       build;
    logic       set_count;
    logic       load_u;
    logic       rd_end;
    logic       chk_end;
    logic       rd_mid;
    logic       srch_step;
    logic       rd_left;
    logic       rd_right;
    logic       set_l;
    logic       set_r;
    logic       div_start;
    logic       upd;
    logic       close_row;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic build_done;
    logic end_hit;
    logic srch_done;
    logic div_done;
  } stat_t;

endpackage

[sv/bbe_if.sv]
// ----------------------------------------------------------------------------
// bbe_if: valid/ready channel carrying a generic payload word
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface bbe_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/bbe_ctrl.sv]
// ----------------------------------------------------------------------------
// bbe_ctrl: sequencer for knot build, span search and the recurrence
// Issues one command word per cycle and steps on datapath status.
// ----------------------------------------------------------------------------
module bbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bbe_pkg::stat_t   stat,
  output bbe_pkg::cmd_t    cmd,
  output logic [bbe_pkg::JW-1:0] j,
  output logic [bbe_pkg::JW-1:0] r,
  output logic [bbe_pkg::JW-1:0] k
);
  import bbe_pkg::*;

  state_t state, state_next;
  logic booted;

  assign cfg_ready = (state == S_IDLE) && booted;
  assign in_ready  = (state == S_IDLE) && booted && !cfg_valid;
  assign out_valid = (state == S_EMIT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!booted) begin
          state_next = S_BUILD;
        end else if (cfg_valid) begin
          cmd.set_count = 1'b1;
          state_next = S_BUILD;
        end else if (in_valid) begin
          cmd.load_u = 1'b1;
          cmd.rd_end = 1'b1;
          state_next = S_END;
        end
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        if (stat.build_done) state_next = S_IDLE;
      end
      S_END: begin
        cmd.chk_end = 1'b1;
        if (stat.end_hit) begin
          cmd.rd_left = 1'b1;
          state_next = S_KNOT;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.rd_mid = 1'b1;
        state_next = S_SRCHW;
      end
      S_SRCHW: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_done) begin
          cmd.rd_left = 1'b1;
          state_next = S_KNOT;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_KNOT: begin
        cmd.set_l = 1'b1;
        cmd.rd_right = 1'b1;
        state_next = S_KNOTW;
      end
      S_KNOTW: begin
        cmd.set_r = 1'b1;
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (r == j - JW'(1)) begin
          cmd.close_row = 1'b1;
          if (j == JW'(Degree)) begin
            state_next = S_EMIT;
          end else begin
            cmd.rd_left = 1'b1;
            state_next = S_KNOT;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (k == JW'(Degree)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      booted <= 1'b0;
      j <= '0;
      r <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      if (state == S_BUILD && stat.build_done) booted <= 1'b1;
      if (cmd.load_u) begin
        j <= JW'(1);
        r <= '0;
        k <= '0;
      end
      if (cmd.upd) begin
        if (cmd.close_row) begin
          j <= j + JW'(1);
          r <= '0;
        end else begin
          r <= r + JW'(1);
        end
      end
      if (cmd.emit) k <= k + JW'(1);
    end
  end
endmodule

[sv/bbe_div.sv]
// ----------------------------------------------------------------------------
// bbe_div: restoring divider, one quotient bit per cycle
// Returns round-half-up of num/den clamped to One, zero when den is zero.
// ----------------------------------------------------------------------------
module bbe_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [bbe_pkg::QW-1:0]  num,
  input  logic [bbe_pkg::VW:0]    den,
  output logic                    done,
  output logic [bbe_pkg::VW-1:0]  quo
);
  import bbe_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] q;
  logic [VW+1:0] rem;
  logic [VW:0]   d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW+1:0] trial;
  logic [QW-1:0] q_full;

  assign trial = {rem[VW:0], q[QW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num + QW'(den >> 1);
      d   <= den;
      rem <= '0;
    end else if (busy) begin
      if (!trial[VW+1]) begin
        rem <= trial;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[VW:0], q[QW-1]};
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  assign q_full = (d == '0) ? '0 : q;
  assign quo = (q_full > QW'(One)) ? One : q_full[VW-1:0];
endmodule

[sv/bbe_dp.sv]
// ----------------------------------------------------------------------------
// bbe_dp: knot memory, span search registers and recurrence datapath
// Builds knots one a cycle, waiting on divides; triangle in small reg files.
// ----------------------------------------------------------------------------
module bbe_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  bbe_pkg::cmd_t          cmd,
  input  logic [bbe_pkg::JW-1:0] j,
  input  logic [bbe_pkg::JW-1:0] r,
  input  logic [bbe_pkg::JW-1:0] k,
  input  logic [bbe_pkg::NW-1:0] cfg_data,
  input  logic [bbe_pkg::VW-1:0] u_in,
  output bbe_pkg::stat_t         stat,
  output logic [7:0]             span_out,
  output logic [bbe_pkg::VW-1:0] value_out
);
  import bbe_pkg::*;

  logic [VW-1:0] knots [KnotDepth];
  logic [VW-1:0] rd_data;
  logic [KW-1:0] rd_addr;
  logic          rd_en;

  logic [NW-1:0] count;
  logic [KW-1:0] bidx;
  logic [VW+NW-1:0] bnum;
  logic [VW-1:0] bval;
  logic [VW-1:0] bq;
  logic          bdone;
  logic          bdiv_go, bdiv_wait;
  logic          ddone;
  logic [VW-1:0] dquo;

  logic [VW-1:0] u;
  logic [KW-1:0] lo, hi, mid, span;
  logic [KW-1:0] lo_n, hi_n, mid_n;
  logic [KW-1:0] span_sel;
  logic          ge_mid;
  logic          srch_done;
  logic          mid_lo_ok;
  logic [VW-1:0] lft [Degree+1];
  logic [VW-1:0] rgt [Degree+1];
  logic [VW-1:0] basis [Degree+1];
  logic [VW-1:0] saved;
  logic [JW-1:0] rn;
  logic [VW-1:0] rgt_new;
  logic [VW-1:0] rr, ll, old, dold, t;
  logic [VW:0]   den;
  logic [QW-1:0] num;

  logic          use_div_b;
  logic [QW-1:0] div_num;
  logic [VW:0]   div_den;

  // knot build
  logic [KW-1:0] last_knot;
  logic [NW-1:0] kden;
  assign last_knot = KW'(count) + KW'(Degree);
  assign kden = count - NW'(Degree);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= NW'(Degree + 1);
      bidx <= '0;
      bdone <= 1'b0;
      bdiv_go <= 1'b0;
      bdiv_wait <= 1'b0;
    end else begin
      bdone <= 1'b0;
      bdiv_go <= 1'b0;
      if (cmd.set_count) begin
        bidx <= '0;
        if (cfg_data < NW'(Degree + 1)) count <= NW'(Degree + 1);
        else if (cfg_data > NW'(MaxCtrl)) count <= NW'(MaxCtrl);
        else count <= cfg_data;
      end else if (cmd.build && !bdone) begin
        if (bdiv_wait) begin
          if (ddone) begin
            bdiv_wait <= 1'b0;
            bidx <= bidx + KW'(1);
            if (bidx == KW'(KnotDepth - 1)) begin
              bdone <= 1'b1;
              bidx <= '0;
            end
          end
        end else if (bidx > KW'(Degree) && bidx < last_knot - KW'(Degree)) begin
          bdiv_go <= 1'b1;
          bdiv_wait <= 1'b1;
        end else begin
          bidx <= bidx + KW'(1);
          if (bidx == KW'(KnotDepth - 1)) begin
            bdone <= 1'b1;
            bidx <= '0;
          end
        end
      end
    end
  end

  assign bnum = (VW+NW)'(bidx - KW'(Degree)) << 16;
  assign bval = (bidx <= KW'(Degree)) ? '0 : One;
  assign bq = bdiv_wait ? dquo : bval;
  assign stat.build_done = bdone;

  always_ff @(posedge clk) begin
    if (cmd.build && !bdone && (!bdiv_wait || ddone)) begin
      knots[bidx] <= bq;
    end
    if (rd_en) rd_data <= knots[rd_addr];
  end

  // addressing
  always_comb begin
    rd_en = 1'b1;
    rd_addr = mid;
    span_sel = span;
    if (cmd.chk_end) span_sel = KW'(count) - KW'(1);
    else if (cmd.srch_step) span_sel = mid;
    if (cmd.rd_end) rd_addr = KW'(count);
    else if (cmd.rd_left) rd_addr = span_sel + KW'(1) - KW'(cmd.close_row ? j + JW'(1) : j);
    else if (cmd.rd_right) rd_addr = span + KW'(j);
    else if (cmd.rd_mid && cmd.chk_end) rd_addr = KW'((KW'(Degree) + KW'(count)) >> 1);
    else if (cmd.rd_mid && cmd.srch_step) rd_addr = mid_n;
    else if (cmd.rd_mid) rd_addr = mid + KW'(1);
  end

  // search
  assign ge_mid = !(u < rd_data);

  always_comb begin
    lo_n = lo;
    hi_n = hi;
    srch_done = 1'b0;
    if (!mid_lo_ok) hi_n = mid;
    else if (ge_mid) lo_n = mid;
    else srch_done = 1'b1;
    mid_n = KW'((({1'b0, lo_n} + {1'b0, hi_n}) >> 1));
  end

  assign stat.srch_done = srch_done;
  assign stat.end_hit = !(u < rd_data);

  always_ff @(posedge clk) begin
    if (cmd.load_u) begin
      u <= (u_in > One) ? One : u_in;
    end
    if (cmd.chk_end) begin
      lo <= KW'(Degree);
      hi <= KW'(count);
      mid <= KW'((KW'(Degree) + KW'(count)) >> 1);
      span <= KW'(count) - KW'(1);
    end
    if (cmd.rd_mid && !cmd.srch_step && !cmd.chk_end) begin
      mid_lo_ok <= ge_mid;
    end
    if (cmd.srch_step) begin
      if (srch_done) span <= mid;
      lo <= lo_n;
      hi <= hi_n;
      mid <= mid_n;
    end
  end

  // recurrence
  assign rn = cmd.upd ? r + JW'(1) : r;
  assign rgt_new = (rd_data >= u) ? rd_data - u : '0;
  assign rr = (cmd.set_r && (rn + JW'(1) == j)) ? rgt_new : rgt[BW'(rn + JW'(1))];
  assign ll = lft[BW'(j - rn)];
  assign dold = basis[BW'(rn)];
  assign old = basis[BW'(r)];
  assign den = {1'b0, rr} + {1'b0, ll};
  assign num = QW'(rr) * QW'(dold);
  assign t = (dquo > old) ? old : dquo;

  always_ff @(posedge clk) begin
    if (cmd.load_u) begin
      for (int i = 0; i <= Degree; i++) begin
        basis[i] <= (i == 0) ? One : '0;
        lft[i] <= '0;
        rgt[i] <= '0;
      end
      saved <= '0;
    end
    if (cmd.set_l) lft[BW'(j)] <= (u >= rd_data) ? u - rd_data : '0;
    if (cmd.set_r) begin
      rgt[BW'(j)] <= rgt_new;
      saved <= '0;
    end
    if (cmd.upd) begin
      basis[BW'(r)] <= saved + t;
      saved <= old - t;
      if (cmd.close_row) basis[BW'(r + JW'(1))] <= old - t;
    end
  end

  assign use_div_b = cmd.build;
  assign div_num = use_div_b ? QW'(bnum) : num;
  assign div_den = use_div_b ? (VW+1)'(kden) : den;

  bbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (bdiv_go || cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (ddone),
    .quo   (dquo)
  );

  assign stat.div_done = ddone;
  assign span_out = span[7:0];
  assign value_out = basis[BW'(k)];
endmodule

[sv/bspline_basis_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_unit: clamped uniform B-spline basis, degree three
// One parameter word in, four basis words out, Cox-de Boor in fixed point.
// ----------------------------------------------------------------------------
// channel   dir  payload
// cfg       in   num_control_points (9)
// in        in   param_u (17)
// out       out  span_index, basis_index, basis_value, last_of_run
//
// Reset builds the knot table one entry a cycle, inner knots waiting on the
// divider; no word is taken until it finishes; a config write does the same.
// An item takes the word and tests the end knot, then makes its search steps,
// two knot reads per row and six divides, then gives one result word a cycle
// while out.ready is high.
// Results are held while out.ready is low.
module bspline_basis_evaluator_unit (
  input  logic clk,
  input  logic rst,
  bbe_if.sink   cfg,
  bbe_if.sink   in,
  bbe_if.source out
);
  import bbe_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [JW-1:0] j, r, k;
  logic [7:0]    span;
  logic [VW-1:0] value;

  bbe_ctrl u_ctrl (
    .clk (clk), .rst (rst),
    .cfg_valid (cfg.valid), .cfg_ready (cfg.ready),
    .in_valid (in.valid), .in_ready (in.ready),
    .out_valid (out.valid), .out_ready (out.ready),
    .stat (stat), .cmd (cmd), .j (j), .r (r), .k (k)
  );

  bbe_dp u_dp (
    .clk (clk), .rst (rst), .cmd (cmd), .j (j), .r (r), .k (k),
    .cfg_data (cfg.data[NW-1:0]), .u_in (in.data[VW-1:0]),
    .stat (stat), .span_out (span), .value_out (value)
  );

  assign out.data = {span, k, value, (k == JW'(Degree))};
endmodule

[sv/bbe_checker.sv]
// ----------------------------------------------------------------------------
// bbe_checker: port-level checks for the basis evaluator
// Watches handshakes and result ordering at the top level.
// ----------------------------------------------------------------------------
module bbe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input logic [28:0] out_data
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during results");
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second word taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped");
  a_first_idx: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_data[20:18] == 3'd0) else $error("bad first index");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid) else $error("config open while busy");
endmodule

bind bspline_basis_evaluator_unit bbe_checker u_chk (
  .clk (clk), .rst (rst),
  .in_valid (in.valid), .in_ready (in.ready),
  .out_valid (out.valid), .out_ready (out.ready),
  .cfg_ready (cfg.ready), .out_data (out.data)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: B-spline basis evaluator unit check
// Sets several control-point counts, drives directed and random parameter
// words, predicts the four basis words of each and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import bbe_pkg::*;

  localparam int OW = 8 + JW + VW + 1;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [7:0]    span;
    logic [JW-1:0] bidx;
    logic [VW-1:0] val;
    logic          last;
  } basis_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbe_if #(NW) cfg_if ();
  bbe_if #(VW) in_if ();
  bbe_if #(OW) out_if ();

  bspline_basis_evaluator_unit uut (
    .clk(clk), .rst(rst), .cfg(cfg_if.sink), .in(in_if.sink), .out(out_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int unsigned ctrl_count;
  logic [VW-1:0] knots [KnotDepth];
  logic [VW-1:0] param_q [$];
  basis_word_t basis_q [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic logic [VW-1:0] round_div(longint unsigned num, longint unsigned den);
    if (den == 0) return '0;
    return VW'((num + den / 2) / den);
  endfunction

  function automatic void set_count(int unsigned raw);
    int unsigned v;
    v = raw & 9'h1FF;
    if (v < Degree + 1) v = Degree + 1;
    if (v > MaxCtrl) v = MaxCtrl;
    ctrl_count = v;
    for (int i = 0; i < KnotDepth; i++) begin
      if (i <= Degree) knots[i] = '0;
      else if (i >= v + Degree - Degree) knots[i] = One;
      else knots[i] = round_div(longint'(i - Degree) * 65536, v - Degree);
    end
  endfunction

  function automatic int unsigned locate_span(int unsigned u);
    int unsigned lo, hi, mid;
    lo = Degree;
    hi = ctrl_count;
    if (u >= knots[ctrl_count]) return ctrl_count - 1;
    mid = (lo + hi) / 2;
    for (int g = 0; g < 64; g++) begin
      if (u < knots[mid]) hi = mid;
      else if (u >= knots[mid + 1]) lo = mid;
      else break;
      mid = (lo + hi) / 2;
    end
    return mid;
  endfunction

  task automatic predict_basis(logic [VW-1:0] raw);
    int unsigned u, span, saved, kl, kr, rr, ll, old, t;
    int unsigned nb [Degree+1];
    int unsigned lf [Degree+1];
    int unsigned rt [Degree+1];
    basis_word_t w;
    u = raw > One ? 65536 : raw;
    span = locate_span(u);
    for (int k = 0; k <= Degree; k++) begin
      nb[k] = 0; lf[k] = 0; rt[k] = 0;
    end
    nb[0] = 65536;
    for (int j = 1; j <= Degree; j++) begin
      saved = 0;
      kl = knots[span + 1 - j];
      kr = knots[span + j];
      lf[j] = u >= kl ? u - kl : 0;
      rt[j] = kr >= u ? kr - u : 0;
      for (int r = 0; r < j; r++) begin
        rr = rt[r + 1];
        ll = lf[j - r];
        old = nb[r];
        t = round_div(longint'(rr) * old, rr + ll);
        if (t > old) t = old;
        nb[r] = saved + t;
        saved = old - t;
      end
      nb[j] = saved;
    end
    for (int k = 0; k <= Degree; k++) begin
      w.span = span[7:0];
      w.bidx = k[JW-1:0];
      w.val = nb[k][VW-1:0];
      w.last = (k == Degree);
      basis_q.push_back(w);
    end
  endtask

  task automatic report(string what, basis_word_t got, basis_word_t want);
    errors++;
    $display("mismatch %s: got span %0d idx %0d val %0d last %0d, want %0d %0d %0d %0d",
             what, got.span, got.bidx, got.val, got.last,
             want.span, want.bidx, want.val, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (param_q.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
        in_if.valid <= 1'b1;
        in_if.data <= param_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 3000;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else if (hold_req || hold_left > 1) out_if.ready <= 1'b0;
    else out_if.ready <= quiet || $urandom_range(99) >= 31;
  end

  always @(posedge clk) begin
    basis_word_t got, want;
    if (!rst && in_if.valid && in_if.ready) predict_basis(in_if.data);
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (basis_q.size() == 0) begin
        want = '0;
        report("unexpected word", got, want);
      end else begin
        want = basis_q.pop_front();
        if (got.span !== want.span) report("span", got, want);
        else if (got.bidx !== want.bidx) report("index", got, want);
        else if (got.val !== want.val) report("value", got, want);
        else if (got.last !== want.last) report("last", got, want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL bspline_basis_evaluator_unit");
      $finish;
    end
  end

  task automatic write_count(int unsigned raw);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= NW'(raw);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    set_count(raw);
  endtask

  task automatic drain();
    while (param_q.size() > 0 || in_if.valid) @(posedge clk);
    while (basis_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic add_random(int n);
    int unsigned sel, k;
    int v;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel == 0) param_q.push_back(VW'($urandom_range(131071)));
      else if (sel == 1) param_q.push_back(VW'($urandom_range(131071, 65536)));
      else if (sel == 2) begin
        k = $urandom_range(ctrl_count + Degree);
        v = int'(knots[k]) + int'($urandom_range(2)) - 1;
        param_q.push_back(VW'(v < 0 ? 0 : v));
      end else param_q.push_back(VW'($urandom_range(65536)));
    end
  endtask

  int unsigned counts [10] = '{256, 0, 511, 5, 7, 100, 4, 0, 0, 0};

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    set_count(4);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    param_q = '{0, 1, 65535, 65536, 65537, 131071, 32768, 16384, 49152, 21845};
    add_random(30);
    drain();
    for (int p = 0; p < 10; p++) begin
      write_count(p < 7 ? counts[p] : $urandom_range(511));
      if (p == 0) begin
        for (int k = 0; k <= ctrl_count + Degree; k += 17) param_q.push_back(knots[k]);
        param_q.push_back(VW'(1)); param_q.push_back(One);
      end
      quiet = (p == 3);
      if (p == 1) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      add_random(42);
      drain();
    end
    if (errors == 0) $display("PASS bspline_basis_evaluator_unit");
    else $display("FAIL bspline_basis_evaluator_unit");
    $finish;
  end

endmodule
